### design/ufb_pkg.sv
// ufb_pkg: types, register indexes and frame byte positions for the upload frame builder
// used by every module of the block, depends on nothing

package ufb_pkg;

  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned FrameBytes = 27;
  localparam int unsigned PosWidth   = $clog2(FrameBytes);

  // byte positions inside a full frame run
  localparam logic [PosWidth-1:0] PosHdrFirst = PosWidth'(0);
  localparam logic [PosWidth-1:0] PosSeqHigh  = PosWidth'(3);
  localparam logic [PosWidth-1:0] PosData     = PosWidth'(20);
  localparam logic [PosWidth-1:0] PosFooterHi = PosWidth'(26);

  localparam logic [13:0] SrcSubnetRst = 14'd101;
  localparam logic [15:0] SrcNodeRst   = 16'd4112;
  localparam logic [13:0] DstSubnetRst = 14'd102;
  localparam logic [15:0] DstNodeRst   = 16'd4112;
  localparam logic [15:0] SeqRst       = 16'd1;

  typedef enum logic [2:0] {
    RegSrcSubnet = 3'd0,
    RegSrcNode   = 3'd1,
    RegDstSubnet = 3'd2,
    RegDstNode   = 3'd3,
    RegHeader    = 3'd4,
    RegExtension = 3'd5,
    RegFooter    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [13:0] source_subnet;
    logic [15:0] source_node;
    logic [13:0] dst_subnet;
    logic [15:0] dest_node;
    logic [15:0] header_word;
    logic [15:0] extension_word;
    logic [15:0] footer_word;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [23:0] payload_length;
    logic [31:0] dtype_code;
    logic [7:0]  ident_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } out_word_t;

endpackage

### design/ufb_cfg_regs.sv
// ufb_cfg_regs: apb register file holding addresses and frame marker words
// depends on ufb_pkg

module ufb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ufb_pkg::AddrWidth-1:0] paddr,
  input  logic [ufb_pkg::DataWidth-1:0] pwdata,
  output logic [ufb_pkg::DataWidth-1:0] prdata,
  output logic                         pready,
  output ufb_pkg::cfg_t                cfg_o
);
  import ufb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegSrcSubnet: cfg_d.source_subnet  = pwdata[13:0];
        RegSrcNode:   cfg_d.source_node    = pwdata[15:0];
        RegDstSubnet: cfg_d.dst_subnet     = pwdata[13:0];
        RegDstNode:   cfg_d.dest_node      = pwdata[15:0];
        RegHeader:    cfg_d.header_word    = pwdata[15:0];
        RegExtension: cfg_d.extension_word = pwdata[15:0];
        RegFooter:    cfg_d.footer_word    = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSrcSubnet: prdata = {18'd0, cfg_q.source_subnet};
      RegSrcNode:   prdata = {16'd0, cfg_q.source_node};
      RegDstSubnet: prdata = {18'd0, cfg_q.dst_subnet};
      RegDstNode:   prdata = {16'd0, cfg_q.dest_node};
      RegHeader:    prdata = {16'd0, cfg_q.header_word};
      RegExtension: prdata = {16'd0, cfg_q.extension_word};
      RegFooter:    prdata = {16'd0, cfg_q.footer_word};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_subnet  <= SrcSubnetRst;
      cfg_q.source_node    <= SrcNodeRst;
      cfg_q.dst_subnet     <= DstSubnetRst;
      cfg_q.dest_node      <= DstNodeRst;
      cfg_q.header_word    <= '0;
      cfg_q.extension_word <= '0;
      cfg_q.footer_word    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### design/ufb_framer.sv
// ufb_framer: input word register, byte position counter and output word register
// depends on ufb_pkg

module ufb_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ufb_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ufb_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ufb_pkg::out_word_t   out_word_o
);
  import ufb_pkg::*;

  logic                 item_valid_q, item_valid_d;
  in_word_t             item_q;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [15:0]          seq_q, seq_d;
  logic [7:0]           chk_q, chk_d;
  logic                 out_valid_q;
  out_word_t            out_q;

  logic                 out_adv, take, item_final, done, in_acc;
  logic [PosWidth-1:0]  end_pos;
  logic [31:0]          source_addr, dst_addr;
  logic [7:0]           frame_bytes [FrameBytes];
  logic [7:0]           cur_byte;

  assign source_addr = {2'b00, cfg_i.source_subnet, cfg_i.source_node};
  assign dst_addr    = {2'b00, cfg_i.dst_subnet, cfg_i.dest_node};

  // full frame image, little-endian fields
  always_comb begin
    frame_bytes[0]  = cfg_i.header_word[7:0];
    frame_bytes[1]  = cfg_i.header_word[15:8];
    frame_bytes[2]  = seq_q[7:0];
    frame_bytes[3]  = seq_q[15:8];
    frame_bytes[4]  = source_addr[7:0];
    frame_bytes[5]  = source_addr[15:8];
    frame_bytes[6]  = source_addr[23:16];
    frame_bytes[7]  = source_addr[31:24];
    frame_bytes[8]  = dst_addr[7:0];
    frame_bytes[9]  = dst_addr[15:8];
    frame_bytes[10] = dst_addr[23:16];
    frame_bytes[11] = dst_addr[31:24];
    frame_bytes[12] = item_q.dtype_code[7:0];
    frame_bytes[13] = item_q.dtype_code[15:8];
    frame_bytes[14] = item_q.dtype_code[23:16];
    frame_bytes[15] = item_q.dtype_code[31:24];
    frame_bytes[16] = item_q.payload_length[7:0];
    frame_bytes[17] = item_q.payload_length[15:8];
    frame_bytes[18] = item_q.payload_length[23:16];
    frame_bytes[19] = item_q.ident_byte;
    frame_bytes[20] = item_q.data_byte;
    frame_bytes[21] = cfg_i.extension_word[7:0];
    frame_bytes[22] = cfg_i.extension_word[15:8];
    frame_bytes[23] = chk_q;
    frame_bytes[24] = 8'h00;
    frame_bytes[25] = cfg_i.footer_word[7:0];
    frame_bytes[26] = cfg_i.footer_word[15:8];
  end

  assign cur_byte   = frame_bytes[pos_q];
  assign end_pos    = item_q.last_of_frame ? PosFooterHi : PosData;
  assign item_final = (pos_q == end_pos);
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign take       = item_valid_q && out_adv;
  assign done       = take && item_final;
  assign in_stall_o = item_valid_q && !done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    pos_d        = pos_q;
    if (in_acc) begin
      item_valid_d = 1'b1;
      pos_d        = in_word_i.first_of_frame ? PosHdrFirst : PosData;
    end else if (done) begin
      item_valid_d = 1'b0;
    end else if (take) begin
      pos_d = pos_q + PosWidth'(1);
    end
  end

  // checksum restarts at the header and clears after the trailer
  always_comb begin
    chk_d = chk_q;
    seq_d = seq_q;
    if (take) begin
      if (pos_q == PosHdrFirst) begin
        chk_d = cur_byte;
      end else if (pos_q == PosFooterHi) begin
        chk_d = '0;
      end else begin
        chk_d = chk_q ^ cur_byte;
      end
      if (pos_q == PosSeqHigh) begin
        seq_d = seq_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      pos_q        <= '0;
      seq_q        <= SeqRst;
      chk_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      pos_q        <= pos_d;
      seq_q        <= seq_d;
      chk_q        <= chk_d;
      if (out_adv) begin
        out_valid_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_word_i;
    end
    if (take) begin
      out_q.out_byte    <= cur_byte;
      out_q.last_of_run <= item_final;
      out_q.frame_end   <= (pos_q == PosFooterHi);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### design/upload_frame_builder_core.sv
// upload_frame_builder_core: top level, apb register file plus byte framer
// depends on ufb_pkg, ufb_cfg_regs and ufb_framer
// the framer registers each input word, then each output byte it yields
// output words: 1 + 20 (first of frame) + 6 (last of frame) per input word,
// one output word per cycle, single output register, while out_stall_i is low
// reset: sequence number 1, checksum 0, address registers to their defaults

module upload_frame_builder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ufb_pkg::AddrWidth-1:0] paddr,
  input  logic [ufb_pkg::DataWidth-1:0] pwdata,
  output logic [ufb_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ufb_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ufb_pkg::out_word_t            out_word_o
);
  import ufb_pkg::*;

  cfg_t cfg;

  ufb_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ufb_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
